FILE: hdl/afm_pkg.sv
`default_nettype none

package afm_pkg;

   localparam int ADDR_W = 8;
   localparam int MSG_DEPTH = 1 << ADDR_W;
   localparam int TICK_DIVIDE = 10;
   localparam logic [3:0] TICK_LAST = 4'(TICK_DIVIDE - 1);
   localparam logic [3:0] BIT_LAST = 4'd9;
   localparam logic [7:0] QUARTER_TURN = 8'd64;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   localparam logic [1:0] EVENT_NONE = 2'd0;
   localparam logic [1:0] EVENT_REPEAT = 2'd1;
   localparam logic [1:0] EVENT_DONE = 2'd2;

   localparam logic [2:0] CSR_SAMPLES_PER_BIT = 3'd0;
   localparam logic [2:0] CSR_MARK_INCREMENT = 3'd1;
   localparam logic [2:0] CSR_SPACE_INCREMENT = 3'd2;
   localparam logic [2:0] CSR_FM_GAIN = 3'd3;
   localparam logic [2:0] CSR_ALT_FORMAT = 3'd4;
   localparam logic [2:0] CSR_REPEAT_COUNT = 3'd5;

   // quarter-wave tables, k = 0..64
   localparam logic [7:0] AMP255 [0:64] = '{
      8'd0, 8'd6, 8'd12, 8'd18, 8'd24, 8'd31, 8'd37, 8'd43, 8'd49, 8'd55, 8'd61,
      8'd68, 8'd74, 8'd79, 8'd85, 8'd91, 8'd97, 8'd103, 8'd109, 8'd114, 8'd120,
      8'd125, 8'd131, 8'd136, 8'd141, 8'd146, 8'd151, 8'd156, 8'd161, 8'd166,
      8'd171, 8'd175, 8'd180, 8'd184, 8'd188, 8'd193, 8'd197, 8'd201, 8'd204,
      8'd208, 8'd212, 8'd215, 8'd218, 8'd221, 8'd224, 8'd227, 8'd230, 8'd233,
      8'd235, 8'd237, 8'd240, 8'd242, 8'd244, 8'd245, 8'd247, 8'd248, 8'd250,
      8'd251, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255
   };
   localparam logic [7:0] AMP127 [0:64] = '{
      8'd0, 8'd3, 8'd6, 8'd9, 8'd12, 8'd15, 8'd18, 8'd21, 8'd24, 8'd27, 8'd30,
      8'd33, 8'd36, 8'd39, 8'd42, 8'd45, 8'd48, 8'd51, 8'd54, 8'd57, 8'd59,
      8'd62, 8'd65, 8'd67, 8'd70, 8'd73, 8'd75, 8'd78, 8'd80, 8'd82, 8'd85,
      8'd87, 8'd89, 8'd91, 8'd94, 8'd96, 8'd98, 8'd100, 8'd102, 8'd103, 8'd105,
      8'd107, 8'd108, 8'd110, 8'd112, 8'd113, 8'd114, 8'd116, 8'd117, 8'd118,
      8'd119, 8'd120, 8'd121, 8'd122, 8'd123, 8'd123, 8'd124, 8'd125, 8'd125,
      8'd126, 8'd126, 8'd126, 8'd126, 8'd126, 8'd127
   };

   typedef struct packed {
      logic              enable;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } msg_wr_type;

   typedef struct packed {
      logic [7:0] cur;
      logic [7:0] nxt;
      logic [7:0] head0;
      logic [7:0] head1;
   } msg_rd_type;

   function automatic logic [6:0] quarter_index(input logic [7:0] idx);
      logic [6:0] r;
      r = {1'b0, idx[5:0]};
      return idx[6] ? 7'd64 - r : r;
   endfunction

   function automatic logic signed [8:0] sine255(input logic [7:0] idx);
      logic [8:0] v;
      v = {1'b0, AMP255[quarter_index(idx)]};
      return idx[7] ? -v : v;
   endfunction

   function automatic logic signed [7:0] sine127(input logic [7:0] idx);
      logic [7:0] v;
      v = AMP127[quarter_index(idx)];
      return idx[7] ? -v : v;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/afm_msg_store.sv
`default_nettype none

module afm_msg_store (
   input  wire logic                      clock,
   input  wire afm_pkg::msg_wr_type       wr,
   input  wire logic [afm_pkg::ADDR_W-1:0] rd_addr,
   output afm_pkg::msg_rd_type            rd
);
   import afm_pkg::*;

   logic [7:0] mem [0:MSG_DEPTH-1];
   logic [ADDR_W-1:0] nxt_addr;
   logic [7:0] cur_ff;
   logic [7:0] nxt_ff;
   logic [7:0] head0_ff;
   logic [7:0] head1_ff;

   assign nxt_addr = rd_addr + ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (wr.enable) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered reads with write bypass
   always_ff @(posedge clock) begin
      if (wr.enable && wr.addr == rd_addr) begin
         cur_ff <= wr.data;
      end else begin
         cur_ff <= mem[rd_addr];
      end
      if (wr.enable && wr.addr == nxt_addr) begin
         nxt_ff <= wr.data;
      end else begin
         nxt_ff <= mem[nxt_addr];
      end
   end

   // shadow copies of the first two bytes for restart
   always_ff @(posedge clock) begin
      if (wr.enable && wr.addr == ADDR_W'(0)) begin
         head0_ff <= wr.data;
      end
      if (wr.enable && wr.addr == ADDR_W'(1)) begin
         head1_ff <= wr.data;
      end
   end

   assign rd.cur = cur_ff;
   assign rd.nxt = nxt_ff;
   assign rd.head0 = head0_ff;
   assign rd.head1 = head1_ff;

endmodule

`default_nettype wire

FILE: hdl/afsk_fm_iq_modulator.sv
// AFSK FM I/Q modulator.
// Request channel (req_valid / req_stall) carries one command per transfer:
// load writes req_byte_value into the message store at req_byte_address,
// start arms transmission, tick produces one I/Q sample. Load and start give
// no response; each tick gives exactly one response transfer on the rsp_
// channel with the I/Q sample, an event code and the repetition count.
// Registers are written through csr_write / csr_index / csr_data while idle,
// which the block does not enforce. A tick passes stages (bit timing and tone
// NCO, FM gain multiply, carrier accumulator and sine/cosine lookup). The
// message store is a 256-byte memory with two registered read ports that
// track the current and next byte position. One command is taken every cycle
// unless rsp_stall is high with a response waiting; then the whole pipeline
// holds and req_stall is raised until the response is taken.
// Reset (synchronous, active high) clears registers, phases and the pipeline,
// and leaves the transmitter finished until a start; the store is not cleared.
`default_nettype none

module afsk_fm_iq_modulator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_mode,
   input  wire logic [7:0]        req_byte_address,
   input  wire logic [7:0]        req_byte_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic signed [7:0]      rsp_i_sample,
   output logic signed [7:0]      rsp_q_sample,
   output logic [1:0]             rsp_event_res,
   output logic [7:0]             rsp_repeats_left,
   input  wire logic              csr_write,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_data
);
   import afm_pkg::*;

   logic        advance;
   logic        req_accept;

   logic [15:0] samples_per_bit_ff;
   logic [31:0] mark_increment_ff;
   logic [31:0] space_increment_ff;
   logic [15:0] fm_gain_ff;
   logic        alt_format_ff;
   logic [7:0]  repeat_count_ff;

   logic [3:0]        tick_div_ff, tick_div_in;
   logic [15:0]       bit_timer_ff, bit_timer_in;
   logic [3:0]        bit_pos_ff, bit_pos_in;
   logic [ADDR_W-1:0] byte_pos_ff, byte_pos_in;
   logic [7:0]        cur_byte_ff, cur_byte_in;
   logic [7:0]        ext_byte_ff, ext_byte_in;
   logic              cur_bit_ff, cur_bit_in;
   logic [31:0]       tone_phase_ff, tone_phase_in;
   logic [31:0]       carrier_ff, carrier_in;
   logic [7:0]        repeats_ff, repeats_in;
   logic              finished_ff, finished_in;

   logic [1:0]  evt;
   logic [7:0]  left;

   msg_wr_type  wr;
   msg_rd_type  rd;

   logic              a_vld_ff;
   logic signed [8:0] a_amp_ff;
   logic [1:0]        a_evt_ff;
   logic [7:0]        a_left_ff;
   logic               b_vld_ff;
   logic signed [25:0] b_prod_ff, b_prod_in;
   logic [1:0]         b_evt_ff;
   logic [7:0]         b_left_ff;
   logic               rsp_valid_ff;
   logic signed [7:0]  rsp_i_ff, rsp_q_ff;
   logic [1:0]         rsp_evt_ff;
   logic [7:0]         rsp_left_ff;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign req_accept = req_valid && advance;

   afm_msg_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (byte_pos_in),
      .rd      (rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_per_bit_ff <= '0;
         mark_increment_ff <= '0;
         space_increment_ff <= '0;
         fm_gain_ff <= '0;
         alt_format_ff <= 1'b0;
         repeat_count_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SAMPLES_PER_BIT: samples_per_bit_ff <= csr_data[15:0];
            CSR_MARK_INCREMENT:  mark_increment_ff <= csr_data;
            CSR_SPACE_INCREMENT: space_increment_ff <= csr_data;
            CSR_FM_GAIN:         fm_gain_ff <= csr_data[15:0];
            CSR_ALT_FORMAT:      alt_format_ff <= csr_data[0];
            CSR_REPEAT_COUNT:    repeat_count_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [7:0]  cur;
      logic [7:0]  ext;
      logic [3:0]  bitp;
      logic [ADDR_W-1:0] bytep;
      logic [7:0]  rep;
      logic        fin;
      logic [9:0]  framed;
      logic        bit_v;

      tick_div_in = tick_div_ff;
      bit_timer_in = bit_timer_ff;
      bit_pos_in = bit_pos_ff;
      byte_pos_in = byte_pos_ff;
      cur_byte_in = cur_byte_ff;
      ext_byte_in = ext_byte_ff;
      cur_bit_in = cur_bit_ff;
      tone_phase_in = tone_phase_ff;
      repeats_in = repeats_ff;
      finished_in = finished_ff;
      evt = EVENT_NONE;
      left = '0;
      wr.enable = 1'b0;
      wr.addr = req_byte_address[ADDR_W-1:0];
      wr.data = req_byte_value;
      cur = '0;
      ext = '0;
      bitp = '0;
      bytep = '0;
      rep = '0;
      fin = 1'b0;
      framed = '0;
      bit_v = 1'b0;

      if (req_accept) begin
         unique case (req_mode)
            MODE_LOAD: begin
               wr.enable = 1'b1;
            end
            MODE_START: begin
               finished_in = 1'b0;
               repeats_in = repeat_count_ff;
               tick_div_in = '0;
               bit_timer_in = '0;
               bit_pos_in = '0;
               byte_pos_in = '0;
               cur_byte_in = '0;
               ext_byte_in = '0;
               cur_bit_in = 1'b0;
            end
            MODE_TICK: begin
               if (tick_div_ff >= TICK_LAST) begin
                  tick_div_in = '0;
                  if (bit_timer_ff >= samples_per_bit_ff) begin
                     bit_timer_in = '0;
                     cur = finished_ff ? cur_byte_ff : rd.cur;
                     ext = finished_ff ? ext_byte_ff : rd.nxt;
                     bitp = bit_pos_ff;
                     bytep = byte_pos_ff;
                     rep = repeats_ff;
                     fin = finished_ff;
                     if (cur == 8'd0) begin
                        if (rep != 8'd0) begin
                           rep = rep - 8'd1;
                           bitp = '0;
                           bytep = '0;
                           cur = rd.head0;
                           ext = rd.head1;
                           evt = EVENT_REPEAT;
                           left = rep;
                        end else begin
                           if (!fin) begin
                              evt = EVENT_DONE;
                           end
                           fin = 1'b1;
                           cur = '0;
                           ext = '0;
                        end
                     end
                     // start bit, byte, then bit 0 of the next byte or a stop bit
                     framed = {1'b0, cur, alt_format_ff ? ext[0] : 1'b1};
                     bit_v = (bitp <= BIT_LAST) ? framed[BIT_LAST - bitp] : framed[0];
                     if (bitp >= BIT_LAST) begin
                        bitp = '0;
                        bytep = bytep + (alt_format_ff ? ADDR_W'(2) : ADDR_W'(1));
                     end else begin
                        bitp = bitp + 4'd1;
                     end
                     cur_byte_in = cur;
                     ext_byte_in = ext;
                     bit_pos_in = bitp;
                     byte_pos_in = bytep;
                     repeats_in = rep;
                     finished_in = fin;
                     cur_bit_in = bit_v;
                  end else begin
                     bit_timer_in = bit_timer_ff + 16'd1;
                  end
                  tone_phase_in = tone_phase_ff +
                                  (cur_bit_in ? mark_increment_ff : space_increment_ff);
               end else begin
                  tick_div_in = tick_div_ff + 4'd1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_div_ff <= '0;
         bit_timer_ff <= '0;
         bit_pos_ff <= '0;
         byte_pos_ff <= '0;
         cur_byte_ff <= '0;
         ext_byte_ff <= '0;
         cur_bit_ff <= 1'b0;
         tone_phase_ff <= '0;
         repeats_ff <= '0;
         finished_ff <= 1'b1;
      end else begin
         tick_div_ff <= tick_div_in;
         bit_timer_ff <= bit_timer_in;
         bit_pos_ff <= bit_pos_in;
         byte_pos_ff <= byte_pos_in;
         cur_byte_ff <= cur_byte_in;
         ext_byte_ff <= ext_byte_in;
         cur_bit_ff <= cur_bit_in;
         tone_phase_ff <= tone_phase_in;
         repeats_ff <= repeats_in;
         finished_ff <= finished_in;
      end
   end

   assign b_prod_in = a_amp_ff * $signed({1'b0, fm_gain_ff});
   assign carrier_in = carrier_ff + {{6{b_prod_ff[25]}}, b_prod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         carrier_ff <= '0;
      end else if (advance) begin
         a_vld_ff <= req_accept && req_mode == MODE_TICK;
         b_vld_ff <= a_vld_ff;
         rsp_valid_ff <= b_vld_ff;
         if (b_vld_ff) begin
            carrier_ff <= carrier_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_amp_ff <= sine255(tone_phase_in[25:18]);
         a_evt_ff <= evt;
         a_left_ff <= left;
         b_prod_ff <= b_prod_in;
         b_evt_ff <= a_evt_ff;
         b_left_ff <= a_left_ff;
         rsp_i_ff <= sine127(carrier_in[25:18] + QUARTER_TURN);
         rsp_q_ff <= sine127(carrier_in[25:18]);
         rsp_evt_ff <= b_evt_ff;
         rsp_left_ff <= b_left_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_i_sample = rsp_i_ff;
   assign rsp_q_sample = rsp_q_ff;
   assign rsp_event_res = rsp_evt_ff;
   assign rsp_repeats_left = rsp_left_ff;

endmodule

`default_nettype wire
